[design/rss_pkg.sv]
// ----------------------------------------------------------------------------
// rss_pkg
// Types and codes shared by the request slice scheduler.
// ----------------------------------------------------------------------------
package rss_pkg;

	localparam int LEN_W  = 31;
	localparam int ID_W   = 16;
	localparam int MAXJ_W = 8;

	localparam logic [1:0] MODE_SJF  = 2'd0;
	localparam logic [1:0] MODE_RR   = 2'd1;
	localparam logic [1:0] MODE_MLFQ = 2'd2;
	localparam logic [1:0] MODE_FCFS = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_SLICE1 = 2'd1;
	localparam logic [1:0] REG_SLICE2 = 2'd2;
	localparam logic [1:0] REG_MAXJ   = 2'd3;

	localparam logic ACT_SUBMIT   = 1'b0;
	localparam logic ACT_DISPATCH = 1'b1;

	localparam logic [LEN_W-1:0]  SLICE1_RST = 31'd8192;
	localparam logic [LEN_W-1:0]  SLICE2_RST = 31'd65536;
	localparam logic [MAXJ_W-1:0] MAXJ_RST   = 8'd100;

	typedef struct packed {
		logic             action;
		logic [ID_W-1:0]  job_id;
		logic [LEN_W-1:0] job_length;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  served_id;
		logic [LEN_W-1:0] send_bytes;
		logic             finished;
		logic [1:0]       level_served;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       index;
		logic [LEN_W-1:0] value;
	} cfgw_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [LEN_W-1:0]  slice1;
		logic [LEN_W-1:0]  slice2;
		logic [MAXJ_W-1:0] max_jobs;
	} cfg_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_LINK, S_WALK, S_INSERT, S_APPEND, S_DEXEC, S_RESULT
	} state_t;

endpackage

[design/rss_req_if.sv]
// ----------------------------------------------------------------------------
// rss_req_if
// Request channel: submit or dispatch items.
// ----------------------------------------------------------------------------
interface rss_req_if;
	import rss_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/rss_rsp_if.sv]
// ----------------------------------------------------------------------------
// rss_rsp_if
// Response channel: one result per request.
// ----------------------------------------------------------------------------
interface rss_rsp_if;
	import rss_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/rss_cfg_if.sv]
// ----------------------------------------------------------------------------
// rss_cfg_if
// Configuration write channel: register index and value.
// ----------------------------------------------------------------------------
interface rss_cfg_if;
	import rss_pkg::*;
	logic  valid;
	logic  ready;
	cfgw_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[design/request_slice_scheduler.sv]
// ----------------------------------------------------------------------------
// request_slice_scheduler
// Job slice scheduler: shortest first, round robin, feedback levels, FCFS.
// ----------------------------------------------------------------------------
// Channels: req carries submit or dispatch items, rsp returns one result per
// request, cfg writes mode, slices and job limit (always ready).
// After reset the link memory is swept to build the free list, with req.ready
// held low until the sweep ends.
// Request path: a refused submit or empty dispatch goes straight to the result;
// a FIFO submit links a free slot and appends; a shortest-first submit walks queue
// 0 and inserts before the first longer job or appends; dispatch frees or requeues.
// A next request is taken only after the previous result is registered in the
// output stage; a stalled rsp holds that result, and the block takes one more
// request, parking its result until the output stage frees.
// ----------------------------------------------------------------------------
module request_slice_scheduler #(
	parameter int JOB_SLOTS = 128,
	parameter int TAG_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	rss_cfg_if.sink   cfg,
	rss_req_if.sink   req,
	rss_rsp_if.source rsp
);
	import rss_pkg::*;

	cfg_t regs;

	rss_cfg u_cfg (.clk, .arst_n, .cfg, .regs);

	rss_core #(.JOB_SLOTS(JOB_SLOTS), .TAG_BITS(TAG_BITS)) u_core (
		.clk, .arst_n, .regs, .req, .rsp);
endmodule

[design/rss_ram.sv]
// ----------------------------------------------------------------------------
// rss_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[design/rss_cfg.sv]
// ----------------------------------------------------------------------------
// rss_cfg
// Configuration register bank.
// ----------------------------------------------------------------------------
module rss_cfg (
	input  logic           clk,
	input  logic           arst_n,
	rss_cfg_if.sink        cfg,
	output rss_pkg::cfg_t  regs
);
	import rss_pkg::*;

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.mode     <= MODE_SJF;
			regs_q.slice1   <= SLICE1_RST;
			regs_q.slice2   <= SLICE2_RST;
			regs_q.max_jobs <= MAXJ_RST;
		end else if (cfg.valid) begin
			unique case (cfg.data.index)
				REG_MODE:   regs_q.mode     <= cfg.data.value[1:0];
				REG_SLICE1: regs_q.slice1   <= cfg.data.value;
				REG_SLICE2: regs_q.slice2   <= cfg.data.value;
				REG_MAXJ:   regs_q.max_jobs <= cfg.data.value[MAXJ_W-1:0];
				default:    ;
			endcase
		end
	end
endmodule

[design/rss_core.sv]
// ----------------------------------------------------------------------------
// rss_core
// Queue sequencer: free list, three linked level queues, sorted insert walk.
// ----------------------------------------------------------------------------
module rss_core #(
	parameter int JOB_SLOTS = 128,
	parameter int TAG_BITS  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  rss_pkg::cfg_t regs,
	rss_req_if.sink       req,
	rss_rsp_if.source     rsp
);
	import rss_pkg::*;

	localparam int SW = $clog2(JOB_SLOTS);
	localparam int CW = $clog2(JOB_SLOTS + 1);
	localparam int HW = (CW > MAXJ_W) ? CW : MAXJ_W;
	localparam int TW = (TAG_BITS < ID_W) ? TAG_BITS : ID_W;

	state_t state_q, state_d;

	logic [SW-1:0] head_q [3];
	logic [SW-1:0] tail_q [3];
	logic [CW-1:0] count_q [3];
	logic [SW-1:0] free_q, s_q, cur_q, prev_q, init_q;
	logic [CW-1:0] held_q, k_q;
	logic          hp_q;
	logic [1:0]    lvl_q, ap_lvl_q;
	logic [LEN_W-1:0] len_q;
	rsp_t          res_q;
	logic          ov_q;
	rsp_t          od_q;

	logic [SW-1:0]    raddr;
	logic             tr_we, lk_we;
	logic [SW-1:0]    tr_waddr, lk_waddr, lk_wdata;
	logic [LEN_W-1:0] rm_wdata, rm_rd;
	logic             rm_we;
	logic [TW-1:0]    tg_rd;
	logic [SW-1:0]    lk_rd;

	rss_ram #(.WIDTH(TW), .DEPTH(JOB_SLOTS)) u_tag (
		.clk, .we(tr_we), .waddr(tr_waddr), .wdata(req.data.job_id[TW-1:0]),
		.raddr, .rdata(tg_rd));
	rss_ram #(.WIDTH(LEN_W), .DEPTH(JOB_SLOTS)) u_rem (
		.clk, .we(rm_we), .waddr(tr_waddr), .wdata(rm_wdata),
		.raddr, .rdata(rm_rd));
	rss_ram #(.WIDTH(SW), .DEPTH(JOB_SLOTS)) u_link (
		.clk, .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
		.raddr, .rdata(lk_rd));

	logic acc, full, none, is_sub;
	logic [1:0] dlvl;
	assign acc    = req.valid && req.ready;
	assign is_sub = req.data.action == ACT_SUBMIT;
	assign full   = (HW'(held_q) >= HW'(regs.max_jobs)) || (held_q >= CW'(JOB_SLOTS));
	assign none   = (count_q[0] == '0) && (count_q[1] == '0) && (count_q[2] == '0);

	always_comb begin
		priority if (count_q[0] != '0) dlvl = 2'd0;
		else if (count_q[1] != '0)     dlvl = 2'd1;
		else                           dlvl = 2'd2;
	end

	// slice and outcome of the job at the head
	logic [LEN_W-1:0] slice, slice_raw;
	logic             done;
	always_comb begin
		if (regs.mode == MODE_SJF || regs.mode == MODE_FCFS) slice_raw = rm_rd;
		else if (regs.mode == MODE_RR || lvl_q == 2'd0)      slice_raw = regs.slice1;
		else                                                 slice_raw = regs.slice2;
		slice = (slice_raw == '0) ? LEN_W'(1) : slice_raw;
		done  = rm_rd <= slice;
	end

	logic longer, last;
	assign longer = rm_rd > len_q;
	assign last   = (k_q + CW'(1)) == count_q[0];

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = ov_q;
	assign rsp.data  = od_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT:   if (init_q == SW'(JOB_SLOTS - 1)) state_d = S_IDLE;
			S_IDLE: begin
				if (acc) begin
					if (is_sub) state_d = full ? S_RESULT : S_LINK;
					else        state_d = none ? S_RESULT : S_DEXEC;
				end
			end
			S_LINK:   state_d = (regs.mode != MODE_SJF || count_q[0] == '0) ? S_APPEND : S_WALK;
			S_WALK: begin
				if (longer)    state_d = S_INSERT;
				else if (last) state_d = S_APPEND;
			end
			S_INSERT: state_d = S_RESULT;
			S_APPEND: state_d = S_RESULT;
			S_DEXEC:  state_d = done ? S_RESULT : S_APPEND;
			S_RESULT: if (!ov_q || rsp.ready) state_d = S_IDLE;
			default:  state_d = S_INIT;
		endcase
	end

	always_comb begin
		raddr    = cur_q;
		tr_we    = 1'b0;
		rm_we    = 1'b0;
		tr_waddr = free_q;
		rm_wdata = req.data.job_length;
		lk_we    = 1'b0;
		lk_waddr = s_q;
		lk_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				lk_we    = 1'b1;
				lk_waddr = init_q;
				lk_wdata = (init_q == SW'(JOB_SLOTS - 1)) ? '0 : init_q + SW'(1);
			end
			S_IDLE: begin
				raddr = is_sub ? free_q : head_q[dlvl];
				tr_we = acc && is_sub && !full;
				rm_we = tr_we;
			end
			S_LINK: begin
				lk_we = 1'b1;
				raddr = head_q[0];
			end
			S_WALK: begin
				raddr = lk_rd;
				if (longer) begin
					lk_we    = 1'b1;
					lk_wdata = cur_q;
				end
			end
			S_INSERT: begin
				lk_we    = hp_q;
				lk_waddr = prev_q;
				lk_wdata = s_q;
			end
			S_APPEND: begin
				lk_we    = count_q[ap_lvl_q] != '0;
				lk_waddr = tail_q[ap_lvl_q];
				lk_wdata = s_q;
			end
			S_DEXEC: begin
				lk_we    = 1'b1;
				lk_wdata = done ? free_q : '0;
				tr_waddr = s_q;
				rm_we    = !done;
				rm_wdata = rm_rd - slice;
			end
			S_RESULT: ;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			init_q  <= '0;
			free_q  <= '0;
			held_q  <= '0;
			ov_q    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
				count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (state_q == S_RESULT && (!ov_q || rsp.ready)) ov_q <= 1'b1;
			else if (ov_q && rsp.ready)                       ov_q <= 1'b0;
			unique case (state_q)
				S_INIT: init_q <= init_q + SW'(1);
				S_IDLE: ;
				S_LINK: begin
					free_q <= lk_rd;
					held_q <= held_q + CW'(1);
				end
				S_INSERT: begin
					if (!hp_q) head_q[0] <= s_q;
					count_q[0] <= count_q[0] + CW'(1);
				end
				S_APPEND: begin
					if (count_q[ap_lvl_q] == '0) head_q[ap_lvl_q] <= s_q;
					tail_q[ap_lvl_q]  <= s_q;
					count_q[ap_lvl_q] <= count_q[ap_lvl_q] + CW'(1);
				end
				S_DEXEC: begin
					head_q[lvl_q]  <= lk_rd;
					count_q[lvl_q] <= count_q[lvl_q] - CW'(1);
					if (done) begin
						free_q <= s_q;
						held_q <= held_q - CW'(1);
					end
				end
				S_RESULT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				res_q <= '0;
				lvl_q <= dlvl;
				len_q <= req.data.job_length;
				ap_lvl_q <= 2'd0;
				s_q   <= is_sub ? free_q : head_q[dlvl];
				if (is_sub && full) res_q.status <= ST_FULL;
				if (!is_sub && none) res_q.status <= ST_EMPTY;
			end
			S_LINK: begin
				cur_q <= head_q[0];
				k_q   <= '0;
				hp_q  <= 1'b0;
			end
			S_WALK: begin
				if (!longer) begin
					prev_q <= cur_q;
					hp_q   <= 1'b1;
					cur_q  <= lk_rd;
					k_q    <= k_q + CW'(1);
				end
			end
			S_DEXEC: begin
				res_q.served_id    <= ID_W'(tg_rd);
				res_q.send_bytes   <= done ? rm_rd : slice;
				res_q.finished     <= done;
				res_q.level_served <= (regs.mode == MODE_MLFQ) ? lvl_q : 2'd0;
				ap_lvl_q <= (regs.mode != MODE_MLFQ) ? 2'd0 :
				            (lvl_q == 2'd2) ? 2'd2 : lvl_q + 2'd1;
			end
			S_RESULT: if (!ov_q || rsp.ready) od_q <= res_q;
			default: ;
		endcase
	end

	logic [CW+1:0] qsum;
	assign qsum = (CW+2)'(count_q[0]) + (CW+2)'(count_q[1]) + (CW+2)'(count_q[2]);

	a_held_sum: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> qsum == (CW+2)'(held_q))
		else $error("queue counts disagree with held jobs");
	a_held_max: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(JOB_SLOTS))
		else $error("held jobs exceed slots");
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DEXEC && done |=> held_q == $past(held_q) - CW'(1))
		else $error("finished job not released");
	a_init_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_INIT |=> state_q != S_INIT)
		else $error("init sweep re-entered");
endmodule
